// ----- rtl/acpb_pkg.sv -----
// Shared types, constants and register indexes of the antialiased circle pixel blender.
package acpb_pkg;

    // Image bounds and coordinate fraction
    localparam int IMG_W     = 800;
    localparam int IMG_H     = 640;
    localparam int FRAC_BITS = 4;

    // Register indexes of the configuration port
    localparam logic [2:0] REG_CENTER_COL    = 3'd0;
    localparam logic [2:0] REG_CENTER_ROW    = 3'd1;
    localparam logic [2:0] REG_RADIUS        = 3'd2;
    localparam logic [2:0] REG_FEATHER_WIDTH = 3'd3;
    localparam logic [2:0] REG_FILL_COLOR    = 3'd4;

    // Reset values of the registers
    localparam logic [11:0] FEATHER_RST = 12'd16;
    localparam logic [31:0] FILL_RST    = 32'd255;

    // Square root pipeline: 52-bit radicand, two bits per stage
    localparam int SQ_N_W    = 52;
    localparam int SQ_STEPS  = SQ_N_W / 2;
    localparam int SQ_ROOT_W = SQ_STEPS;
    localparam int SQ_REM_W  = SQ_ROOT_W + 2;

    // Coverage divider: quotient below 256, one bit per stage
    localparam int DIV_STEPS = 8;
    localparam int DIV_REM_W = 21;

    // Reciprocal of 255 for 16-bit dividends: floor(x/255) = (x*RECIP_255) >> 23
    localparam logic [15:0] RECIP_255 = 16'h8081;

    typedef struct packed {
        logic signed [15:0] center_col;
        logic signed [15:0] center_row;
        logic [13:0]        radius;
        logic [11:0]        feather_width;
        logic [31:0]        fill_color;
    } t_cfg;

    // Per-item data that rides along every stage
    typedef struct packed {
        logic       cov;
        logic [7:0] old_red;
        logic [7:0] old_green;
        logic [7:0] old_blue;
    } t_side;

    // Coverage result handed from the divider to the blender
    typedef struct packed {
        t_side      side;
        logic       sat;
        logic       zro;
        logic [7:0] quo;
    } t_cov;

endpackage

// ----- rtl/acpb_geom.sv -----
// Geometry stages: coverage test and squared-distance radicand of each pixel.
module acpb_geom (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  acpb_pkg::t_cfg       i_cfg,
    input  logic                 i_vld,
    input  logic [9:0]           i_col,
    input  logic [9:0]           i_row,
    input  acpb_pkg::t_side      i_side,
    output logic                 o_vld,
    output logic [acpb_pkg::SQ_N_W-1:0] o_n,
    output acpb_pkg::t_side      o_side
);

    logic [3:0] r_vld;

    // Stage 1: offsets and span flags
    logic signed [18:0] x2, y2, n_dy, n_dx, a, b, n_t;
    logic signed [17:0] lo, hi, rowq;
    logic               n_ok;
    acpb_pkg::t_side    n_s1_side;
    logic signed [18:0] r_s1_dy, r_s1_dx, r_s1_t;
    acpb_pkg::t_side    r_s1_side;

    // Stage 2: squares
    logic [29:0]     r_s2_r2sq;
    logic [34:0]     r_s2_dysq, r_s2_dxsq, r_s2_tsq;
    logic            r_s2_tpos;
    acpb_pkg::t_side r_s2_side;
    logic signed [37:0] dysq_f, dxsq_f, tsq_f;
    logic [14:0]     r2;

    // Stage 3: radicand and distance sum
    logic signed [37:0] rad;
    logic [34:0]        r_s3_dsq;
    acpb_pkg::t_side    r_s3_side;
    logic               n_cov3;
    acpb_pkg::t_side    n_s3_side;

    // Stage 4: scale by 65025
    logic [acpb_pkg::SQ_N_W-1:0] r_s4_n;
    acpb_pkg::t_side             r_s4_side;

    assign x2 = $signed({{2{i_cfg.center_col[15]}}, i_cfg.center_col, 1'b0});
    assign y2 = $signed({{2{i_cfg.center_row[15]}}, i_cfg.center_row, 1'b0});
    assign r2 = {i_cfg.radius, 1'b0};

    always_comb begin
        n_dy = y2 - $signed({4'b0, i_row, 1'b1, 4'b0});
        n_dx = x2 - $signed({4'b0, i_col, 1'b1, 4'b0});
        a    = x2 - $signed({4'b0, i_col, 5'b0});
        b    = $signed({3'b0, ({1'b0, i_col} + 11'd1), 5'b0}) - x2;
        n_t  = (a > b) ? a : b;
        lo   = $signed({{2{i_cfg.center_row[15]}}, i_cfg.center_row})
               - $signed({4'b0, i_cfg.radius});
        hi   = $signed({{2{i_cfg.center_row[15]}}, i_cfg.center_row})
               + $signed({4'b0, i_cfg.radius});
        rowq = $signed({4'b0, i_row, 4'b0});
        n_ok = ({3'b0, i_col} < 13'(acpb_pkg::IMG_W)) &&
               ({3'b0, i_row} < 13'(acpb_pkg::IMG_H)) &&
               !(rowq < lo || rowq > hi);
        n_s1_side     = i_side;
        n_s1_side.cov = n_ok;
    end

    assign dysq_f = r_s1_dy * r_s1_dy;
    assign dxsq_f = r_s1_dx * r_s1_dx;
    assign tsq_f  = r_s1_t * r_s1_t;

    always_comb begin
        rad    = $signed({8'b0, r_s2_r2sq}) - $signed({3'b0, r_s2_dysq});
        n_cov3 = r_s2_side.cov && (rad >= 0) &&
                 !(r_s2_tpos && ($signed({3'b0, r_s2_tsq}) > rad));
        n_s3_side     = r_s2_side;
        n_s3_side.cov = n_cov3;
    end

    // Advance valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[2:0], i_vld};
        end
    end

    // Advance payload
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s1_dy   <= n_dy;
            r_s1_dx   <= n_dx;
            r_s1_t    <= n_t;
            r_s1_side <= n_s1_side;

            r_s2_r2sq <= r2 * r2;
            r_s2_dysq <= dysq_f[34:0];
            r_s2_dxsq <= dxsq_f[34:0];
            r_s2_tsq  <= tsq_f[34:0];
            r_s2_tpos <= (r_s1_t > 0);
            r_s2_side <= r_s1_side;

            r_s3_dsq  <= r_s2_dxsq + r_s2_dysq;
            r_s3_side <= n_s3_side;

            r_s4_n    <= (acpb_pkg::SQ_N_W'(r_s3_dsq) << 16)
                         - (acpb_pkg::SQ_N_W'(r_s3_dsq) << 9)
                         + acpb_pkg::SQ_N_W'(r_s3_dsq);
            r_s4_side <= r_s3_side;
        end
    end

    assign o_vld  = r_vld[3];
    assign o_n    = r_s4_n;
    assign o_side = r_s4_side;

endmodule

// ----- rtl/acpb_sqrt.sv -----
// Pipelined digit-by-digit square root, two radicand bits per stage.
module acpb_sqrt (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_en,
    input  logic                             i_vld,
    input  logic [acpb_pkg::SQ_N_W-1:0]      i_n,
    input  acpb_pkg::t_side                  i_side,
    output logic                             o_vld,
    output logic [acpb_pkg::SQ_ROOT_W-1:0]   o_root,
    output logic                             o_inexact,
    output acpb_pkg::t_side                  o_side
);

    localparam int STEPS  = acpb_pkg::SQ_STEPS;
    localparam int N_W    = acpb_pkg::SQ_N_W;
    localparam int ROOT_W = acpb_pkg::SQ_ROOT_W;
    localparam int REM_W  = acpb_pkg::SQ_REM_W;

    logic                  r_vld  [STEPS];
    logic [ROOT_W-1:0]     r_root [STEPS];
    logic [REM_W-1:0]      r_rem  [STEPS];
    logic [N_W-1:0]        r_n    [STEPS];
    acpb_pkg::t_side       r_side [STEPS];

    for (genvar g = 0; g < STEPS; g++) begin : g_stage
        logic              vld_in;
        logic [ROOT_W-1:0] root_in;
        logic [REM_W-1:0]  rem_in;
        logic [N_W-1:0]    n_in;
        acpb_pkg::t_side   side_in;
        logic [REM_W+1:0]  acc, trial;

        if (g == 0) begin : g_first
            assign vld_in  = i_vld;
            assign root_in = '0;
            assign rem_in  = '0;
            assign n_in    = i_n;
            assign side_in = i_side;
        end else begin : g_next
            assign vld_in  = r_vld[g-1];
            assign root_in = r_root[g-1];
            assign rem_in  = r_rem[g-1];
            assign n_in    = r_n[g-1];
            assign side_in = r_side[g-1];
        end

        // Bring down the next two radicand bits and try the root digit
        assign acc   = {rem_in, n_in[N_W-1-2*g -: 2]};
        assign trial = (REM_W+2)'({root_in, 2'b01});

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[g] <= 1'b0;
            end else if (i_en) begin
                r_vld[g] <= vld_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (acc >= trial) begin
                    r_rem[g]  <= REM_W'(acc - trial);
                    r_root[g] <= {root_in[ROOT_W-2:0], 1'b1};
                end else begin
                    r_rem[g]  <= REM_W'(acc);
                    r_root[g] <= {root_in[ROOT_W-2:0], 1'b0};
                end
                r_n[g]    <= n_in;
                r_side[g] <= side_in;
            end
        end
    end

    assign o_vld     = r_vld[STEPS-1];
    assign o_root    = r_root[STEPS-1];
    assign o_inexact = (r_rem[STEPS-1] != '0);
    assign o_side    = r_side[STEPS-1];

endmodule

// ----- rtl/acpb_div.sv -----
// Coverage stages: edge distance, saturation flags and restoring divide by the feather.
module acpb_div (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_en,
    input  acpb_pkg::t_cfg                 i_cfg,
    input  logic                           i_vld,
    input  logic [acpb_pkg::SQ_ROOT_W-1:0] i_root,
    input  logic                           i_inexact,
    input  acpb_pkg::t_side                i_side,
    output logic                           o_vld,
    output acpb_pkg::t_cov                 o_cov
);

    localparam int STEPS = acpb_pkg::DIV_STEPS;
    localparam int REM_W = acpb_pkg::DIV_REM_W;

    logic [14:0]         r2;
    logic [12:0]         f2;
    logic [22:0]         r2_255;
    logic [20:0]         lim;
    logic [26:0]         s_ceil;

    // Stage 0: w = 255*r - ceil(255*d)
    logic signed [27:0]  r_w;
    acpb_pkg::t_side     r_w_side;
    logic                r_w_vld;

    // Stage 1: flags and divider seed
    logic                r_p_vld;
    logic [REM_W-1:0]    r_p_rem;
    acpb_pkg::t_cov      r_p_cov;
    acpb_pkg::t_cov      n_p_cov;

    logic                r_vld [STEPS];
    logic [REM_W-1:0]    r_rem [STEPS];
    acpb_pkg::t_cov      r_cov [STEPS];

    assign r2     = {i_cfg.radius, 1'b0};
    assign f2     = {i_cfg.feather_width, 1'b0};
    assign r2_255 = {r2, 8'b0} - 23'(r2);
    assign lim    = {f2, 8'b0} - 21'(f2);
    assign s_ceil = 27'(i_root) + 27'(i_inexact);

    // Saturation flags and cleared quotient
    always_comb begin
        n_p_cov      = '0;
        n_p_cov.side = r_w_side;
        n_p_cov.sat  = (r_w >= $signed({7'b0, lim}));
        n_p_cov.zro  = (r_w <= 0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w_vld <= 1'b0;
            r_p_vld <= 1'b0;
        end else if (i_en) begin
            r_w_vld <= i_vld;
            r_p_vld <= r_w_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_w      <= $signed({5'b0, r2_255}) - $signed({1'b0, s_ceil});
            r_w_side <= i_side;

            r_p_cov  <= n_p_cov;
            r_p_rem  <= r_w[REM_W-1:0];
        end
    end

    for (genvar g = 0; g < STEPS; g++) begin : g_stage
        logic             vld_in;
        logic [REM_W-1:0] rem_in, dvs, n_rem;
        acpb_pkg::t_cov   cov_in, n_cov;

        if (g == 0) begin : g_first
            assign vld_in = r_p_vld;
            assign rem_in = r_p_rem;
            assign cov_in = r_p_cov;
        end else begin : g_next
            assign vld_in = r_vld[g-1];
            assign rem_in = r_rem[g-1];
            assign cov_in = r_cov[g-1];
        end

        // Shifted divisor for quotient bit STEPS-1-g
        assign dvs = REM_W'(f2) << (STEPS - 1 - g);

        // Subtract where it fits and set the quotient bit
        always_comb begin
            n_cov = cov_in;
            if (rem_in >= dvs) begin
                n_rem = rem_in - dvs;
                n_cov.quo[STEPS-1-g] = 1'b1;
            end else begin
                n_rem = rem_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[g] <= 1'b0;
            end else if (i_en) begin
                r_vld[g] <= vld_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_cov[g] <= n_cov;
                r_rem[g] <= n_rem;
            end
        end
    end

    assign o_vld = r_vld[STEPS-1];
    assign o_cov = r_cov[STEPS-1];

endmodule

// ----- rtl/acpb_blend.sv -----
// Blend stages: coverage select, channel products, divide by 255 and output register.
module acpb_blend (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  logic [31:0]     i_fill,
    input  logic            i_vld,
    input  acpb_pkg::t_cov  i_cov,
    output logic            o_vld,
    output logic            o_covered,
    output logic [7:0]      o_red,
    output logic [7:0]      o_green,
    output logic [7:0]      o_blue,
    output logic [7:0]      o_alpha
);

    logic [2:0]      r_vld;
    logic [7:0]      f, fi;
    logic [15:0]     n_p_red, n_p_grn, n_p_blu;
    logic [15:0]     r_p_red, r_p_grn, r_p_blu;
    acpb_pkg::t_side r_p_side, r_q_side;
    logic [31:0]     m_red, m_grn, m_blu;
    logic [7:0]      r_q_red, r_q_grn, r_q_blu;

    // Pick the coverage value
    always_comb begin
        if (i_cov.sat) begin
            f = 8'd255;
        end else if (i_cov.zro) begin
            f = 8'd0;
        end else begin
            f = i_cov.quo;
        end
        fi = 8'd255 - f;
    end

    // Inverted-channel weighted sum
    assign n_p_red = {8'b0, 8'd255 - i_cov.side.old_red} * {8'b0, fi}
                     + {8'b0, 8'd255 - i_fill[31:24]} * {8'b0, f};
    assign n_p_grn = {8'b0, 8'd255 - i_cov.side.old_green} * {8'b0, fi}
                     + {8'b0, 8'd255 - i_fill[23:16]} * {8'b0, f};
    assign n_p_blu = {8'b0, 8'd255 - i_cov.side.old_blue} * {8'b0, fi}
                     + {8'b0, 8'd255 - i_fill[15:8]} * {8'b0, f};

    assign m_red = r_p_red * acpb_pkg::RECIP_255;
    assign m_grn = r_p_grn * acpb_pkg::RECIP_255;
    assign m_blu = r_p_blu * acpb_pkg::RECIP_255;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[1:0], i_vld};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p_red  <= n_p_red;
            r_p_grn  <= n_p_grn;
            r_p_blu  <= n_p_blu;
            r_p_side <= i_cov.side;

            r_q_red  <= m_red[30:23];
            r_q_grn  <= m_grn[30:23];
            r_q_blu  <= m_blu[30:23];
            r_q_side <= r_p_side;

            // Output register
            o_covered <= r_q_side.cov;
            o_red     <= r_q_side.cov ? 8'd255 - r_q_red : r_q_side.old_red;
            o_green   <= r_q_side.cov ? 8'd255 - r_q_grn : r_q_side.old_green;
            o_blue    <= r_q_side.cov ? 8'd255 - r_q_blu : r_q_side.old_blue;
            o_alpha   <= r_q_side.cov ? i_fill[7:0] : 8'd0;
        end
    end

    assign o_vld = r_vld[2];

endmodule

// ----- rtl/antialiased_circle_pixel_blend.sv -----
// Top level of the antialiased filled-circle pixel blender.
//
// Shades one pixel per item for a filled circle with a feathered edge.
// Input stream (s_axis): pixel column, row and old red/green/blue values.
// Output stream (m_axis): blended red/green/blue and fill alpha in tdata,
// covered flag in tuser; an uncovered pixel returns its old color, alpha 0.
// Config channel: i_cfg_addr selects center_col, center_row, radius,
// feather_width or fill_color; writes are always taken (o_cfg_ready high)
// and must only occur while no item is in flight.
// Throughput: one item per cycle while the output is not stalled. The pipeline
// is built of 4 geometry stages, the 26-stage square root (two radicand bits
// per stage), 10 coverage/divide stages and 3 blend stages.
// When the receiver stalls, the whole pipeline holds and s_axis_tready
// drops; nothing is lost or repeated. Reset (synchronous, active low)
// clears all valid bits and restores the register defaults: center 0,
// radius 0, feather 16, fill color 0x000000ff.
module antialiased_circle_pixel_blend (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [9:0] pixel_col, [19:10] pixel_row, [27:20] old_red, [35:28] old_green,
    // [43:36] old_blue, [47:44] zero
    input  logic [47:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [7:0] new_red, [15:8] new_green, [23:16] new_blue, [31:24] new_alpha
    output logic [31:0] m_axis_tdata,
    // [0] covered
    output logic        m_axis_tuser,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_addr,
    input  logic [31:0] i_cfg_data
);

    acpb_pkg::t_cfg  r_cfg;
    acpb_pkg::t_side in_side;
    logic            en;

    logic                           g_vld, q_vld, d_vld;
    logic [acpb_pkg::SQ_N_W-1:0]    g_n;
    acpb_pkg::t_side                g_side, q_side;
    logic [acpb_pkg::SQ_ROOT_W-1:0] q_root;
    logic                           q_inexact;
    acpb_pkg::t_cov                 d_cov;

    // Advance the pipeline unless the output item is stalled
    assign en            = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = en;
    assign o_cfg_ready   = 1'b1;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.center_col    <= '0;
            r_cfg.center_row    <= '0;
            r_cfg.radius        <= '0;
            r_cfg.feather_width <= acpb_pkg::FEATHER_RST;
            r_cfg.fill_color    <= acpb_pkg::FILL_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_addr)
                acpb_pkg::REG_CENTER_COL:    r_cfg.center_col    <= i_cfg_data[15:0];
                acpb_pkg::REG_CENTER_ROW:    r_cfg.center_row    <= i_cfg_data[15:0];
                acpb_pkg::REG_RADIUS:        r_cfg.radius        <= i_cfg_data[13:0];
                acpb_pkg::REG_FEATHER_WIDTH: r_cfg.feather_width <= i_cfg_data[11:0];
                acpb_pkg::REG_FILL_COLOR:    r_cfg.fill_color    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign in_side.cov       = 1'b0;
    assign in_side.old_red   = s_axis_tdata[27:20];
    assign in_side.old_green = s_axis_tdata[35:28];
    assign in_side.old_blue  = s_axis_tdata[43:36];

    acpb_geom u_geom (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_cfg   (r_cfg),
        .i_vld   (s_axis_tvalid),
        .i_col   (s_axis_tdata[9:0]),
        .i_row   (s_axis_tdata[19:10]),
        .i_side  (in_side),
        .o_vld   (g_vld),
        .o_n     (g_n),
        .o_side  (g_side)
    );

    acpb_sqrt u_sqrt (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (en),
        .i_vld     (g_vld),
        .i_n       (g_n),
        .i_side    (g_side),
        .o_vld     (q_vld),
        .o_root    (q_root),
        .o_inexact (q_inexact),
        .o_side    (q_side)
    );

    acpb_div u_div (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (en),
        .i_cfg     (r_cfg),
        .i_vld     (q_vld),
        .i_root    (q_root),
        .i_inexact (q_inexact),
        .i_side    (q_side),
        .o_vld     (d_vld),
        .o_cov     (d_cov)
    );

    acpb_blend u_blend (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (en),
        .i_fill    (r_cfg.fill_color),
        .i_vld     (d_vld),
        .i_cov     (d_cov),
        .o_vld     (m_axis_tvalid),
        .o_covered (m_axis_tuser),
        .o_red     (m_axis_tdata[7:0]),
        .o_green   (m_axis_tdata[15:8]),
        .o_blue    (m_axis_tdata[23:16]),
        .o_alpha   (m_axis_tdata[31:24])
    );

endmodule

// ----- rtl/acpb_checker.sv -----
// Port-level checks of the pixel blender, bound to its top level.
module acpb_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [31:0] m_axis_tdata,
    input logic        m_axis_tuser
);

    // A stalled output item holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output item changed while stalled");

    // Input is refused only while the output is stalled
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
        else $error("input refused without output stall");

    // An uncovered pixel carries zero alpha
    a_alpha: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata[31:24] == 8'd0)
        else $error("uncovered pixel with nonzero alpha");

    // Reset empties the pipeline
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid right after reset");

endmodule

bind antialiased_circle_pixel_blend acpb_checker u_acpb_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
